[hdl/upe_pkg.sv]
// Shared types, constants and helper functions for the URL percent encoder.
package upe_pkg;

  // Configuration register indexes
  localparam logic CFG_REQUEST_PATH       = 1'b0;
  localparam logic CFG_ENCODE_APOSTROPHES = 1'b1;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  localparam logic [3:0] NIBBLE_MASK = 4'h0F;

  // Bit b is set when byte b passes through unchanged
  localparam logic [255:0] SAFE_MAP = {
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h2BFF_7792, 32'h0000_0000
  };

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One classified source byte: escape or single character
  typedef struct packed {
    logic       esc;   // 1: emit '%' and two hex digits of data
    logic [7:0] data;  // output char, or source byte when esc
    logic       fin;   // last byte of the string
  } upe_entry_t;

  // Upper-case hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [3:0] n;
    n = nib & NIBBLE_MASK;
    if (n < 4'd10) begin
      hex_char = CH_ZERO + {4'd0, n};
    end else begin
      hex_char = CH_UPPER_A + {4'd0, n} - 8'd10;
    end
  endfunction

endpackage

[hdl/upe_front.sv]
// Front end: configuration registers and classification of source bytes.
module upe_front
  import upe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_fin,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output upe_entry_t push_entry
);

  logic request_path;
  logic encode_apostrophes;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      request_path       <= 1'b0;
      encode_apostrophes <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REQUEST_PATH:       request_path       <= cfg_data;
        CFG_ENCODE_APOSTROPHES: encode_apostrophes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Classify: first matching rule wins
  always_comb begin
    push_entry.fin = in_fin;
    priority if (in_byte == CH_NUL && request_path) begin
      push_entry.esc  = 1'b0;
      push_entry.data = in_byte;
    end else if (in_byte == CH_APOS && encode_apostrophes) begin
      push_entry.esc  = 1'b1;
      push_entry.data = in_byte;
    end else if (SAFE_MAP[in_byte]) begin
      push_entry.esc  = 1'b0;
      push_entry.data = in_byte;
    end else if (in_byte == CH_QUEST && request_path) begin
      push_entry.esc  = 1'b0;
      push_entry.data = in_byte;
    end else if (in_byte == CH_SPACE) begin
      push_entry.esc  = 1'b0;
      push_entry.data = CH_PLUS;
    end else begin
      push_entry.esc  = 1'b1;
      push_entry.data = in_byte;
    end
  end

endmodule

[hdl/upe_queue.sv]
// Short register queue that decouples the front end from the back end.
module upe_queue
  import upe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  upe_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output upe_entry_t head
);

  upe_entry_t           slots [QDEPTH];
  logic [QAW-1:0]       wr_ptr;
  logic [QAW-1:0]       rd_ptr;
  logic [QCW-1:0]       count;

  assign full       = (count == QCW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue pop while empty");

endmodule

[hdl/upe_back.sv]
// Back end: expands queued entries into output bytes through an output register.
module upe_back
  import upe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  upe_entry_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end
);

  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_HIGH  = 3'b010,
    PH_LOW   = 3'b100
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic       load;
  logic       take;
  logic       last_beat;
  logic [7:0] beat_byte;

  assign load      = !out_valid || out_ready;
  assign take      = load && head_valid;
  assign last_beat = !head.esc || (phase == PH_LOW);
  assign pop       = take && last_beat;

  // Select the byte for the current phase
  always_comb begin
    unique case (phase)
      PH_FIRST: beat_byte = head.esc ? CH_PERCENT : head.data;
      PH_HIGH:  beat_byte = hex_char(head.data[7:4]);
      PH_LOW:   beat_byte = hex_char(head.data[3:0]);
      default:  beat_byte = head.data;
    endcase
  end

  // Step through the escape sequence
  always_comb begin
    phase_next = phase;
    if (take) begin
      if (last_beat) begin
        phase_next = PH_FIRST;
      end else begin
        unique case (phase)
          PH_FIRST: phase_next = PH_HIGH;
          PH_HIGH:  phase_next = PH_LOW;
          default:  phase_next = PH_FIRST;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= head_valid;
      end
    end
  end

  // Hold output payload until the transaction completes
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte       <= beat_byte;
      out_run_last   <= last_beat;
      out_string_end <= last_beat && head.fin;
    end
  end

  a_mid_escape_has_head: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_FIRST) |-> (head_valid && head.esc))
    else $error("escape phase without queued escape entry");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_string_end) |-> out_run_last)
    else $error("string end on a byte that is not run last");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    (pop && head.esc) |-> (phase == PH_LOW))
    else $error("escape entry popped before its last digit");

endmodule

[hdl/url_percent_encoder.sv]
// An accepted byte is stored in the queue, then registered in the back end.
// Throughput: one output byte per cycle from the back end while it has
// queued entries and m_axis_tready is high; a byte that passes gives one
// output byte, a percent escape three. A 4-entry queue lets the input
// keep flowing while escapes drain. Reset (rst, synchronous) empties the
// queue, drops any pending output and clears both configuration registers to 0.
module url_percent_encoder
  import upe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] run_last
  output logic       m_axis_tlast    // string_end
);

  logic       q_full;
  logic       push;
  upe_entry_t push_entry;
  logic       pop;
  logic       head_valid;
  upe_entry_t head;

  upe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_byte    (s_axis_tdata),
    .in_fin     (s_axis_tlast),
    .q_full     (q_full),
    .in_ready   (s_axis_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  upe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  upe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_byte       (m_axis_tdata),
    .out_run_last   (m_axis_tuser),
    .out_string_end (m_axis_tlast)
  );

endmodule
